[hw/rtl/tcc_pkg.sv]
// Shared types and constants for the text console cursor engine.
package tcc_pkg;

    localparam int unsigned CELL_SHIFT = 3;

    localparam logic [1:0] REQ_PRINT = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] CMD_FILL   = 2'd0;
    localparam logic [1:0] CMD_GLYPH  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [31:0] CURSOR_WHITE = 32'h00FF_FFFF;

    localparam logic [1:0] CFG_TEXT_COLOR   = 2'd0;
    localparam logic [1:0] CFG_BACK_COLOR   = 2'd1;
    localparam logic [1:0] CFG_BLINK_PERIOD = 2'd2;

    localparam logic [31:0] TEXT_COLOR_RST   = 32'h00FF_FFFF;
    localparam logic [31:0] BACK_COLOR_RST   = 32'h0000_0020;
    localparam logic [23:0] BLINK_PERIOD_RST = 24'd200000;

    localparam int unsigned MAX_CMDS = 4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [9:0]  x_pixel;
        logic [8:0]  y_pixel;
        logic [7:0]  glyph;
        logic [31:0] fore_color;
        logic [31:0] fill_color;
    } draw_cmd_t;

endpackage

[hw/rtl/text_console_cursor_engine.sv]
// Text console cursor engine: turns print, tick and clear requests into drawing commands.
//
// Usage. Requests arrive on the s_ stream: s_tuser carries the request type (print,
// tick, clear) and s_tdata the character byte. Drawing commands leave on the m_ stream:
// m_tuser is the command code, m_tdata holds the cell coordinates, glyph and colours,
// and m_tlast marks the final command caused by one request. The cfg_ channel writes
// text colour, background colour and blink period; it is always ready, and the user
// must write it only while the block is idle, which the block itself does not enforce.
// An accepted request waits in the input register and is then expanded into a batch
// of up to four commands in the command register, from which they are offered in order.
// The command register drains one command a cycle while the receiver is ready: a
// printed character gives three or four commands, a newline two or three, and a clear
// or a blink tick one; a tick that causes no command only advances the blink counter.
// The next request waits in the input register and is expanded in the same cycle as
// the last command leaves. Reset (aresetn low, synchronous) empties both registers, homes
// the cursor, clears the blink counter and phase, and restores the register defaults.
// When the receiver stalls, the current command holds; one more request is taken into
// the input register and s_tready then drops until the batch has drained.
module text_console_cursor_engine
    import tcc_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = 640,
    parameter int unsigned SCREEN_HEIGHT = 480
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [9:0] x_pixel, [18:10] y_pixel, [26:19] glyph,
                                   // [58:27] fore_color, [90:59] fill_color, zero above
    output logic [1:0]  m_tuser,   // [1:0] cmd
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned TEXT_COLS = SCREEN_WIDTH >> CELL_SHIFT;
    localparam int unsigned TEXT_ROWS = SCREEN_HEIGHT >> CELL_SHIFT;
    localparam int unsigned COL_W = (TEXT_COLS > 1) ? $clog2(TEXT_COLS) : 1;
    localparam int unsigned ROW_W = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam logic [COL_W:0]   COLS_V   = (COL_W + 1)'(TEXT_COLS);
    localparam logic [ROW_W:0]   ROWS_V   = (ROW_W + 1)'(TEXT_ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);

    logic [31:0]      text_color_reg;
    logic [31:0]      back_color_reg;
    logic [23:0]      blink_period_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] line_reg, line_next;
    logic [23:0]      ticks_reg, ticks_next;
    logic             blink_reg, blink_next;

    logic             in_valid_reg;
    logic [1:0]       in_req_reg;
    logic [7:0]       in_char_reg;

    draw_cmd_t        batch_reg [MAX_CMDS];
    draw_cmd_t        batch_next [MAX_CMDS];
    logic [2:0]       cnt_reg, cnt_next;
    logic [1:0]       idx_reg;

    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   line_inc;
    logic [23:0]      tick_inc;
    logic [1:0]       slot;
    logic             wrap;
    logic             out_fire;
    logic             finishing;
    logic             batch_free;
    logic             load;
    draw_cmd_t        cur;

    function automatic draw_cmd_t make_fill(input logic [COL_W-1:0] c,
                                            input logic [ROW_W-1:0] r,
                                            input logic [31:0] color);
        draw_cmd_t        d;
        logic [COL_W+12:0] xw;
        logic [ROW_W+11:0] yw;
        xw = {10'd0, c, 3'd0};
        yw = {9'd0, r, 3'd0};
        d            = '0;
        d.cmd        = CMD_FILL;
        d.x_pixel    = xw[9:0];
        d.y_pixel    = yw[8:0];
        d.fore_color = color;
        return d;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg   <= TEXT_COLOR_RST;
            back_color_reg   <= BACK_COLOR_RST;
            blink_period_reg <= BLINK_PERIOD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TEXT_COLOR:   text_color_reg   <= cfg_data;
                CFG_BACK_COLOR:   back_color_reg   <= cfg_data;
                CFG_BLINK_PERIOD: blink_period_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign out_fire   = m_tvalid && m_tready;
    assign finishing  = out_fire && (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign batch_free = (cnt_reg == 3'd0) || finishing;
    assign load       = in_valid_reg && batch_free;
    assign s_tready   = !in_valid_reg || load;

    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign line_inc = {1'b0, line_reg} + 1'b1;
    assign tick_inc = ticks_reg + 24'd1;

    always_comb begin
        for (int i = 0; i < MAX_CMDS; i++) begin
            batch_next[i] = '0;
        end
        cnt_next   = 3'd0;
        col_next   = col_reg;
        line_next  = line_reg;
        ticks_next = ticks_reg;
        blink_next = blink_reg;
        slot       = 2'd1;
        wrap       = 1'b0;
        case (in_req_reg)
            REQ_PRINT: begin
                batch_next[0] = make_fill(col_reg, line_reg, back_color_reg);
                if (in_char_reg == NEWLINE_CODE) begin
                    wrap = 1'b1;
                end else begin
                    batch_next[1]            = make_fill(col_reg, line_reg, text_color_reg);
                    batch_next[1].cmd        = CMD_GLYPH;
                    batch_next[1].glyph      = in_char_reg;
                    batch_next[1].fill_color = back_color_reg;
                    slot                     = 2'd2;
                    wrap                     = (col_inc >= COLS_V);
                    col_next                 = col_inc[COL_W-1:0];
                end
                if (wrap) begin
                    col_next = '0;
                    if (line_inc >= ROWS_V) begin
                        batch_next[slot]            = '0;
                        batch_next[slot].cmd        = CMD_SCROLL;
                        batch_next[slot].fill_color = back_color_reg;
                        slot                        = slot + 2'd1;
                        line_next                   = LAST_ROW;
                    end else begin
                        line_next = line_inc[ROW_W-1:0];
                    end
                end
                batch_next[slot] = make_fill(col_next, line_next, CURSOR_WHITE);
                cnt_next         = {1'b0, slot} + 3'd1;
            end
            REQ_TICK: begin
                if (tick_inc > blink_period_reg) begin
                    ticks_next    = '0;
                    blink_next    = !blink_reg;
                    batch_next[0] = make_fill(col_reg, line_reg,
                                              blink_reg ? back_color_reg : CURSOR_WHITE);
                    cnt_next      = 3'd1;
                end else begin
                    ticks_next = tick_inc;
                end
            end
            REQ_CLEAR: begin
                batch_next[0].cmd        = CMD_CLEAR;
                batch_next[0].fill_color = back_color_reg;
                cnt_next                 = 3'd1;
                col_next                 = '0;
                line_next                = '0;
                ticks_next               = '0;
                blink_next               = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            idx_reg      <= 2'd0;
            col_reg      <= '0;
            line_reg     <= '0;
            ticks_reg    <= '0;
            blink_reg    <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                cnt_reg   <= cnt_next;
                idx_reg   <= 2'd0;
                col_reg   <= col_next;
                line_reg  <= line_next;
                ticks_reg <= ticks_next;
                blink_reg <= blink_next;
            end else if (finishing) begin
                cnt_reg <= 3'd0;
                idx_reg <= 2'd0;
            end else if (out_fire) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg  <= s_tuser;
            in_char_reg <= s_tdata;
        end
        if (load) begin
            for (int i = 0; i < MAX_CMDS; i++) begin
                batch_reg[i] <= batch_next[i];
            end
        end
    end

    assign cur      = batch_reg[idx_reg];
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign m_tuser  = cur.cmd;
    assign m_tdata  = {5'd0, cur.fill_color, cur.fore_color, cur.glyph,
                       cur.y_pixel, cur.x_pixel};

endmodule

[hw/rtl/tcc_checker.sv]
// Port-level checks for the text console cursor engine, bound to the top level.
module tcc_checker
    import tcc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // hold a stalled item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled command changed");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("command valid after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CMD_CLEAR) |-> m_tlast)
        else $error("clear not the only command of its request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CMD_SCROLL) |-> !m_tlast && (m_tdata[58:0] == '0))
        else $error("scroll ended a request or carried a cell");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == CMD_GLYPH) |-> !m_tlast)
        else $error("glyph not followed by a cursor redraw");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
